// ===== src/whm_pkg.sv =====
`default_nettype none
package whm_pkg;

   localparam int NUM_BINS = 256;
   localparam int SLOT_W   = $clog2(NUM_BINS);
   localparam int WGT_W    = 40;
   localparam int ACC_W    = WGT_W + SLOT_W;
   localparam int SUM_W    = ACC_W + SLOT_W;
   localparam int KEY_W    = 34;
   localparam int EXC_W    = WGT_W + 2;
   localparam int ALU_W    = 128;
   localparam int DEN_W    = 64;
   localparam int STEP_W   = $clog2(ALU_W) + 1;
   localparam int CNT_W    = $clog2(ALU_W);

   localparam logic [WGT_W-1:0] WGT_MAX = {WGT_W{1'b1}};

   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_REPORT = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_DROPPED = 2'd1;
   localparam logic [1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [1:0] STATUS_NO_DEN  = 2'd3;

   localparam logic CSR_BIN_WIDTH = 1'b0;
   localparam logic CSR_BIN_BASE  = 1'b1;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic                    start;
      alu_op_type              op;
      logic signed [ALU_W-1:0] a;
      logic [DEN_W-1:0]        b;
      logic [STEP_W-1:0]       steps;
   } alu_req_type;

   typedef struct packed {
      logic             done;
      logic             neg;
      logic [ALU_W-1:0] q;
   } alu_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_DIV,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_WALK_ADDR,
      ST_WALK_DATA,
      ST_MEAN_MUL1,
      ST_MEAN_MUL2,
      ST_MEAN_DIV,
      ST_MED_MUL1,
      ST_MED_MUL2,
      ST_MED_MUL3,
      ST_MED_DIV
   } state_type;

   function automatic logic signed [ALU_W-1:0] odd_centre(input logic signed [KEY_W-1:0] key);
      logic signed [KEY_W:0] odd;
      odd = {key, 1'b1};
      return {{(ALU_W-KEY_W-1){odd[KEY_W]}}, odd};
   endfunction

   function automatic logic [31:0] sat32(input logic [ALU_W-1:0] q, input logic neg);
      logic big;
      big = |q[ALU_W-1:32];
      if (neg) begin
         if (big || q[31:0] > 32'h8000_0000) begin
            return 32'h8000_0000;
         end
         return ~q[31:0] + 32'd1;
      end
      if (big || q[31]) begin
         return 32'h7FFF_FFFF;
      end
      return q[31:0];
   endfunction

endpackage
`default_nettype wire

// ===== src/weighted_histogram_mean_median.sv =====
// channel  | ports                                          | handshake
// ---------+------------------------------------------------+-------------------------
// request  | req_func, req_sample_value, req_sample_weight  | start while busy is low
// result   | rsp_status/total/mean/median                   | rsp_strobe, one cycle
// csr      | csr_index, csr_wdata                           | csr_we, no wait
//
// clear and unused func: answered from idle; add: 32-step divide + bin read and update
// report: walks the touched span bin by bin (read, then accumulate), then the mean and
// median, all on one shared shift-add / shift-subtract unit, one bit a cycle
// reset clears the bin valid bits at once, so no clearing pass is needed
// the receiver cannot stall: every transaction yields one rsp_strobe pulse
`default_nettype none
module weighted_histogram_mean_median (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_sample_value,
   input  wire logic [15:0] req_sample_weight,
   output      logic        rsp_strobe,
   output      logic [1:0]  rsp_status,
   output      logic [39:0] rsp_total_weight,
   output      logic [31:0] rsp_mean_value,
   output      logic [31:0] rsp_median_value,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);
   import whm_pkg::*;

   state_type            state_ff, state_in;
   logic [30:0]          width_ff;
   logic signed [31:0]   base_ff;
   logic [WGT_W-1:0]     total_ff, total_in;
   logic [SLOT_W-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic                 any_ff, any_in;
   logic [NUM_BINS-1:0]  valid_ff, valid_in;
   logic                 rd_vld_ff;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [15:0]          weight_ff, weight_in;
   logic [1:0]           status_ff, status_in;
   logic [31:0]          mean_ff, mean_in;
   logic [SLOT_W-1:0]    s_ff, s_in;
   logic [ACC_W-1:0]     p_ff, p_in;
   logic [SUM_W-1:0]     a_ff, a_in;
   logic [WGT_W-1:0]     c_ff, c_in;
   logic [SLOT_W-1:0]    last_ff, last_in;
   logic                 found_ff, found_in;
   logic [WGT_W-1:0]     wlo_ff, wlo_in, wlo1_ff, wlo1_in;
   logic signed [KEY_W-1:0] mk_ff, mk_in;
   logic [WGT_W-1:0]     mw_ff, mw_in;
   logic signed [EXC_W-1:0] mexc_ff, mexc_in;
   logic [SLOT_W-1:0]    mj_ff, mj_in;
   logic [ALU_W-1:0]     x_ff, x_in;

   logic                 rsp_strobe_in;
   logic [1:0]           rsp_status_in;
   logic [39:0]          rsp_total_in;
   logic [31:0]          rsp_mean_in, rsp_median_in;

   alu_req_type          alu_req;
   alu_rsp_type          alu_rsp;

   logic [SLOT_W-1:0]    raddr;
   logic                 ram_we;
   logic [WGT_W-1:0]     ram_wdata, rd_data, word;
   logic [30:0]          width_eff;
   logic [WGT_W:0]       sum41;
   logic [31:0]          quo;
   logic signed [32:0]   kbin;
   logic signed [33:0]   slot34;
   logic [WGT_W+1:0]     twice_cw;
   logic [WGT_W:0]       twice_wlo;
   logic signed [KEY_W-1:0] key_s, key_lo, key_last;

   whm_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   whm_ram #(.WIDTH(WGT_W), .DEPTH(NUM_BINS)) u_bins (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_ff),
      .wdata (ram_wdata),
      .raddr (raddr),
      .rdata (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         width_ff   <= 31'd65536;
         base_ff    <= -32'sd128;
         total_ff   <= '0;
         lo_ff      <= '0;
         hi_ff      <= '0;
         any_ff     <= 1'b0;
         valid_ff   <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         total_ff   <= total_in;
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         any_ff     <= any_in;
         valid_ff   <= valid_in;
         rsp_strobe <= rsp_strobe_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BIN_WIDTH: width_ff <= csr_wdata[30:0];
               CSR_BIN_BASE:  base_ff  <= csr_wdata;
               default:       width_ff <= width_ff;
            endcase
         end
      end
      rd_vld_ff        <= valid_ff[raddr];
      slot_ff          <= slot_in;
      weight_ff        <= weight_in;
      status_ff        <= status_in;
      mean_ff          <= mean_in;
      s_ff             <= s_in;
      p_ff             <= p_in;
      a_ff             <= a_in;
      c_ff             <= c_in;
      last_ff          <= last_in;
      found_ff         <= found_in;
      wlo_ff           <= wlo_in;
      wlo1_ff          <= wlo1_in;
      mk_ff            <= mk_in;
      mw_ff            <= mw_in;
      mexc_ff          <= mexc_in;
      mj_ff            <= mj_in;
      x_ff             <= x_in;
      rsp_status       <= rsp_status_in;
      rsp_total_weight <= rsp_total_in;
      rsp_mean_value   <= rsp_mean_in;
      rsp_median_value <= rsp_median_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign width_eff = (width_ff == '0) ? 31'd1 : width_ff;
   assign raddr     = (state_ff == ST_ADD_RD) ? slot_ff : s_ff;
   assign word      = rd_vld_ff ? rd_data : '0;
   assign key_s     = KEY_W'(base_ff) + KEY_W'(s_ff);
   assign key_lo    = KEY_W'(base_ff) + KEY_W'(lo_ff);
   assign key_last  = KEY_W'(base_ff) + KEY_W'(last_ff);

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      any_in        = any_ff;
      valid_in      = valid_ff;
      slot_in       = slot_ff;
      weight_in     = weight_ff;
      status_in     = status_ff;
      mean_in       = mean_ff;
      s_in          = s_ff;
      p_in          = p_ff;
      a_in          = a_ff;
      c_in          = c_ff;
      last_in       = last_ff;
      found_in      = found_ff;
      wlo_in        = wlo_ff;
      wlo1_in       = wlo1_ff;
      mk_in         = mk_ff;
      mw_in         = mw_ff;
      mexc_in       = mexc_ff;
      mj_in         = mj_ff;
      x_in          = x_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status;
      rsp_total_in  = rsp_total_weight;
      rsp_mean_in   = rsp_mean_value;
      rsp_median_in = rsp_median_value;
      alu_req       = '0;
      ram_we        = 1'b0;
      ram_wdata     = '0;
      sum41         = '0;
      quo           = alu_rsp.q[31:0];
      kbin          = '0;
      slot34        = '0;
      twice_cw      = '0;
      twice_wlo     = {wlo_ff, 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_func)
                  FUNC_ADD: begin
                     weight_in     = req_sample_weight;
                     alu_req.start = 1'b1;
                     alu_req.op    = ALU_DIV;
                     alu_req.a     = {req_sample_value, {(ALU_W-32){1'b0}}};
                     alu_req.b     = DEN_W'(width_eff);
                     alu_req.steps = STEP_W'(32);
                     state_in      = ST_ADD_DIV;
                  end
                  FUNC_REPORT: begin
                     if (!any_ff || total_ff == '0 || hi_ff < lo_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_total_in  = total_ff;
                        rsp_mean_in   = '0;
                        rsp_median_in = '0;
                     end else begin
                        status_in = STATUS_OK;
                        s_in      = lo_ff;
                        p_in      = '0;
                        a_in      = '0;
                        c_in      = '0;
                        last_in   = lo_ff;
                        found_in  = 1'b0;
                        wlo_in    = '0;
                        wlo1_in   = '0;
                        state_in  = ST_WALK_ADDR;
                     end
                  end
                  FUNC_CLEAR: begin
                     valid_in      = '0;
                     total_in      = '0;
                     lo_in         = '0;
                     hi_in         = '0;
                     any_in        = 1'b0;
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_total_in  = '0;
                     rsp_mean_in   = '0;
                     rsp_median_in = '0;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_total_in  = total_ff;
                     rsp_mean_in   = '0;
                     rsp_median_in = '0;
                  end
               endcase
            end
         end

         ST_ADD_DIV: begin
            if (alu_rsp.done) begin
               kbin   = alu_rsp.neg ? (-$signed({1'b0, quo}) - 33'sd1) : $signed({1'b0, quo});
               slot34 = 34'(kbin) - 34'(base_ff);
               if (slot34[33] || (slot34[33:SLOT_W] != '0)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_DROPPED;
                  rsp_total_in  = total_ff;
                  rsp_mean_in   = '0;
                  rsp_median_in = '0;
                  state_in      = ST_IDLE;
               end else begin
                  slot_in  = slot34[SLOT_W-1:0];
                  state_in = ST_ADD_RD;
               end
            end
         end

         ST_ADD_RD: begin
            state_in = ST_ADD_WR;
         end

         ST_ADD_WR: begin
            sum41     = {1'b0, word} + (WGT_W+1)'(weight_ff);
            ram_we    = 1'b1;
            ram_wdata = sum41[WGT_W] ? WGT_MAX : sum41[WGT_W-1:0];
            valid_in[slot_ff] = 1'b1;
            sum41     = {1'b0, total_ff} + (WGT_W+1)'(weight_ff);
            total_in  = sum41[WGT_W] ? WGT_MAX : sum41[WGT_W-1:0];
            if (!any_ff) begin
               lo_in  = slot_ff;
               hi_in  = slot_ff;
               any_in = 1'b1;
            end else begin
               if (slot_ff < lo_ff) begin
                  lo_in = slot_ff;
               end
               if (slot_ff > hi_ff) begin
                  hi_in = slot_ff;
               end
            end
            rsp_strobe_in = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_total_in  = total_in;
            rsp_mean_in   = '0;
            rsp_median_in = '0;
            state_in      = ST_IDLE;
         end

         ST_WALK_ADDR: begin
            state_in = ST_WALK_DATA;
         end

         ST_WALK_DATA: begin
            // a sums the prefix before each bin: the distance-to-top weighting
            p_in = p_ff + ACC_W'(word);
            a_in = a_ff + SUM_W'(p_ff);
            if (s_ff == lo_ff) begin
               wlo_in = word;
            end
            if (s_ff == lo_ff + SLOT_W'(1)) begin
               wlo1_in = word;
            end
            twice_cw = {1'b0, c_ff, 1'b0} + {1'b0, word, 1'b0};
            if (!found_ff) begin
               if (twice_cw > {2'b0, total_ff}) begin
                  found_in = 1'b1;
                  mk_in    = key_last;
                  mw_in    = word;
                  mexc_in  = EXC_W'(total_ff) - EXC_W'({c_ff, 1'b0});
                  mj_in    = s_ff - last_ff;
               end else if (word != '0) begin
                  c_in    = c_ff + word;
                  last_in = s_ff;
               end
            end
            if (s_ff == hi_ff) begin
               alu_req.start = 1'b1;
               alu_req.op    = ALU_MUL;
               alu_req.a     = odd_centre(key_s);
               alu_req.b     = DEN_W'(p_in);
               alu_req.steps = STEP_W'(ACC_W);
               state_in      = ST_MEAN_MUL1;
            end else begin
               s_in     = s_ff + SLOT_W'(1);
               state_in = ST_WALK_ADDR;
            end
         end

         ST_MEAN_MUL1: begin
            if (alu_rsp.done) begin
               alu_req.start = 1'b1;
               alu_req.op    = ALU_MUL;
               alu_req.a     = alu_rsp.q - {{(ALU_W-SUM_W-1){1'b0}}, a_ff, 1'b0};
               alu_req.b     = DEN_W'(width_eff);
               alu_req.steps = STEP_W'(31);
               state_in      = ST_MEAN_MUL2;
            end
         end

         ST_MEAN_MUL2: begin
            if (alu_rsp.done) begin
               alu_req.start = 1'b1;
               alu_req.op    = ALU_DIV;
               alu_req.a     = alu_rsp.q;
               alu_req.b     = DEN_W'({total_ff, 1'b0});
               alu_req.steps = STEP_W'(ALU_W);
               state_in      = ST_MEAN_DIV;
            end
         end

         ST_MEAN_DIV: begin
            if (alu_rsp.done) begin
               mean_in = sat32(alu_rsp.q, alu_rsp.neg);
               if (lo_ff == hi_ff || twice_wlo > {1'b0, total_ff} || found_ff) begin
                  if (lo_ff == hi_ff) begin
                     mk_in   = key_lo;
                     mw_in   = WGT_W'(1);
                     mexc_in = '0;
                     mj_in   = '0;
                  end else if (twice_wlo > {1'b0, total_ff}) begin
                     mk_in   = key_lo;
                     mw_in   = wlo1_ff;
                     mexc_in = EXC_W'(total_ff) - EXC_W'(twice_wlo);
                     mj_in   = SLOT_W'(1);
                  end
                  if (mw_in == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_NO_DEN;
                     rsp_total_in  = total_ff;
                     rsp_mean_in   = mean_in;
                     rsp_median_in = '0;
                     state_in      = ST_IDLE;
                  end else begin
                     alu_req.start = 1'b1;
                     alu_req.op    = ALU_MUL;
                     alu_req.a     = odd_centre(mk_in);
                     alu_req.b     = DEN_W'(mw_in);
                     alu_req.steps = STEP_W'(WGT_W);
                     state_in      = ST_MED_MUL1;
                  end
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_total_in  = total_ff;
                  rsp_mean_in   = mean_in;
                  rsp_median_in = '0;
                  state_in      = ST_IDLE;
               end
            end
         end

         ST_MED_MUL1: begin
            if (alu_rsp.done) begin
               x_in          = alu_rsp.q;
               alu_req.start = 1'b1;
               alu_req.op    = ALU_MUL;
               alu_req.a     = ALU_W'(mexc_ff);
               alu_req.b     = DEN_W'(mj_ff);
               alu_req.steps = STEP_W'(SLOT_W);
               state_in      = ST_MED_MUL2;
            end
         end

         ST_MED_MUL2: begin
            if (alu_rsp.done) begin
               alu_req.start = 1'b1;
               alu_req.op    = ALU_MUL;
               alu_req.a     = x_ff + alu_rsp.q;
               alu_req.b     = DEN_W'(width_eff);
               alu_req.steps = STEP_W'(31);
               state_in      = ST_MED_MUL3;
            end
         end

         ST_MED_MUL3: begin
            if (alu_rsp.done) begin
               alu_req.start = 1'b1;
               alu_req.op    = ALU_DIV;
               alu_req.a     = alu_rsp.q;
               alu_req.b     = DEN_W'({mw_ff, 1'b0});
               alu_req.steps = STEP_W'(ALU_W);
               state_in      = ST_MED_DIV;
            end
         end

         ST_MED_DIV: begin
            if (alu_rsp.done) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_total_in  = total_ff;
               rsp_mean_in   = mean_ff;
               rsp_median_in = sat32(alu_rsp.q, alu_rsp.neg);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

// ===== src/whm_ram.sv =====
`default_nettype none
module whm_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// ===== src/whm_alu.sv =====
`default_nettype none
module whm_alu (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire whm_pkg::alu_req_type req,
   output      whm_pkg::alu_rsp_type rsp
);
   import whm_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   alu_op_type       op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ALU_W-1:0] x_ff, x_in;
   logic [ALU_W-1:0] acc_ff, acc_in;
   logic [DEN_W-1:0] b_ff, b_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] rem_sh;
   logic [STEP_W-1:0] steps_m1;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      acc_ff <= acc_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      b_in     = b_ff;
      rem_in   = rem_ff;
      rem_sh   = {rem_ff[DEN_W-2:0], x_ff[ALU_W-1]};
      steps_m1 = req.steps - STEP_W'(1);
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         cnt_in  = steps_m1[CNT_W-1:0];
         acc_in  = '0;
         rem_in  = '0;
         b_in    = req.b;
         neg_in  = (req.op == ALU_DIV) && req.a[ALU_W-1];
         x_in    = neg_in ? ALU_W'(-req.a) : ALU_W'(req.a);
      end else if (busy_ff) begin
         case (op_ff)
            ALU_MUL: begin
               if (b_ff[0]) begin
                  acc_in = acc_ff + x_ff;
               end
               x_in = {x_ff[ALU_W-2:0], 1'b0};
               b_in = {1'b0, b_ff[DEN_W-1:1]};
            end
            ALU_DIV: begin
               x_in = {x_ff[ALU_W-2:0], 1'b0};
               if (rem_sh >= b_ff) begin
                  rem_in = rem_sh - b_ff;
                  acc_in = {acc_ff[ALU_W-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  acc_in = {acc_ff[ALU_W-2:0], 1'b0};
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.neg  = neg_ff;
   assign rsp.q    = acc_ff;
endmodule
`default_nettype wire
